// ===== hdl/vdcd_pkg.sv =====
`default_nettype none

package vdcd_pkg;

    // Command codes kept while the operands of a command are gathered.
    localparam logic [1:0] CC_IDLE  = 2'd0;
    localparam logic [1:0] CC_POINT = 2'd1;
    localparam logic [1:0] CC_LINE  = 2'd2;
    localparam logic [1:0] CC_REL   = 2'd3;

    // Command bytes of the stream.
    localparam logic [7:0] CMD_POINT = 8'd2;
    localparam logic [7:0] CMD_LINE  = 8'd3;
    localparam logic [7:0] CMD_REL   = 8'd4;

    // Operand byte counts at which words are complete.
    localparam logic [3:0] CNT_FIRST_X  = 4'd2;
    localparam logic [3:0] CNT_FIRST_Y  = 4'd4;
    localparam logic [3:0] CNT_SECOND_X = 4'd6;
    localparam logic [3:0] CNT_REL_DX   = 4'd1;

    // Draw kinds.
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_LINE  = 1'b1;

    // Base of the vertical flip.
    localparam logic [16:0] Y_FLIP_BASE = 17'd1023;

    // One drawing result as it leaves the block.
    typedef struct packed {
        logic        kind;
        logic [15:0] start_x;
        logic [16:0] start_y_flipped;
        logic [15:0] end_x;
        logic [16:0] end_y_flipped;
    } t_draw;

    // Flip a 16-bit y coordinate as 1023 minus y, modulo 2^17.
    function automatic logic [16:0] flip_y(input logic [15:0] y);
        flip_y = Y_FLIP_BASE - {1'b0, y};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vdcd_parser.sv =====
`default_nettype none

module vdcd_parser
    import vdcd_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_data_byte,
    output logic            o_res_valid,
    output t_draw           o_res
);

    localparam int PadW = 16 - COORD_WIDTH;

    logic [1:0]             r_cmd, n_cmd;
    logic [3:0]             r_cnt, n_cnt;
    logic [7:0]             r_hi, n_hi;
    logic [COORD_WIDTH-1:0] r_fx, n_fx;
    logic [COORD_WIDTH-1:0] r_fy, n_fy;
    logic [COORD_WIDTH-1:0] r_sx, n_sx;
    logic [COORD_WIDTH-1:0] r_bx, n_bx;
    logic [COORD_WIDTH-1:0] r_by, n_by;

    logic [3:0]             w_n;
    logic [15:0]            w_word16;
    logic [COORD_WIDTH-1:0] w_word;
    logic [COORD_WIDTH-1:0] w_rel_x;
    logic [COORD_WIDTH-1:0] w_rel_y;

    // The word just completed and the relative end point.
    assign w_n      = r_cnt + 4'd1;
    assign w_word16 = {r_hi, i_data_byte};
    assign w_word   = w_word16[COORD_WIDTH-1:0];
    assign w_rel_x  = r_bx + {{(COORD_WIDTH-8){r_hi[7]}}, r_hi};
    assign w_rel_y  = r_by + {{(COORD_WIDTH-8){i_data_byte[7]}}, i_data_byte};

    // Decode one byte against the gathering state.
    always_comb begin
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_hi        = r_hi;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_sx        = r_sx;
        n_bx        = r_bx;
        n_by        = r_by;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_cmd)
            CC_IDLE: begin
                n_cnt = 4'd0;
                if (i_data_byte == CMD_POINT) begin
                    n_cmd = CC_POINT;
                end else if (i_data_byte == CMD_LINE) begin
                    n_cmd = CC_LINE;
                end else if (i_data_byte == CMD_REL) begin
                    n_cmd = CC_REL;
                end
            end
            CC_REL: begin
                n_cnt = w_n;
                if (w_n == CNT_REL_DX) begin
                    n_hi = i_data_byte;
                end else begin
                    o_res_valid           = 1'b1;
                    o_res.kind            = KIND_LINE;
                    o_res.start_x         = {{PadW{1'b0}}, r_bx};
                    o_res.start_y_flipped = flip_y({{PadW{1'b0}}, r_by});
                    o_res.end_x           = {{PadW{1'b0}}, w_rel_x};
                    o_res.end_y_flipped   = flip_y({{PadW{1'b0}}, w_rel_y});
                    n_bx  = w_rel_x;
                    n_by  = w_rel_y;
                    n_cmd = CC_IDLE;
                    n_cnt = 4'd0;
                end
            end
            CC_POINT: begin
                n_cnt = w_n;
                if (w_n[0]) begin
                    n_hi = i_data_byte;
                end else if (w_n == CNT_FIRST_X) begin
                    n_fx = w_word;
                end else begin
                    o_res_valid           = 1'b1;
                    o_res.kind            = KIND_POINT;
                    o_res.start_x         = {{PadW{1'b0}}, r_fx};
                    o_res.start_y_flipped = flip_y({{PadW{1'b0}}, w_word});
                    o_res.end_x           = {{PadW{1'b0}}, r_fx};
                    o_res.end_y_flipped   = flip_y({{PadW{1'b0}}, w_word});
                    n_bx  = r_fx;
                    n_by  = w_word;
                    n_cmd = CC_IDLE;
                    n_cnt = 4'd0;
                end
            end
            CC_LINE: begin
                n_cnt = w_n;
                if (w_n[0]) begin
                    n_hi = i_data_byte;
                end else if (w_n == CNT_FIRST_X) begin
                    n_fx = w_word;
                end else if (w_n == CNT_FIRST_Y) begin
                    n_fy = w_word;
                end else if (w_n == CNT_SECOND_X) begin
                    n_sx = w_word;
                end else begin
                    o_res_valid           = 1'b1;
                    o_res.kind            = KIND_LINE;
                    o_res.start_x         = {{PadW{1'b0}}, r_fx};
                    o_res.start_y_flipped = flip_y({{PadW{1'b0}}, r_fy});
                    o_res.end_x           = {{PadW{1'b0}}, r_sx};
                    o_res.end_y_flipped   = flip_y({{PadW{1'b0}}, w_word});
                    n_bx  = r_sx;
                    n_by  = w_word;
                    n_cmd = CC_IDLE;
                    n_cnt = 4'd0;
                end
            end
            default: begin
                n_cmd = CC_IDLE;
                n_cnt = 4'd0;
            end
        endcase
    end

    // State advances only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CC_IDLE;
            r_cnt <= '0;
            r_hi  <= '0;
            r_fx  <= '0;
            r_fy  <= '0;
            r_sx  <= '0;
            r_bx  <= '0;
            r_by  <= '0;
        end else if (i_take) begin
            r_cmd <= n_cmd;
            r_cnt <= n_cnt;
            r_hi  <= n_hi;
            r_fx  <= n_fx;
            r_fy  <= n_fy;
            r_sx  <= n_sx;
            r_bx  <= n_bx;
            r_by  <= n_by;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/vector_display_command_decoder_core.sv =====
// A result word appears in the cycle after the input word that completes its command.
// Throughput: one input word per cycle while the sink does not stall; the parse state and the
// output register update together, so only downstream stall slows the stream.
// Reset: synchronous, active low; clears the command state, beam position and
// the output valid flag.
`default_nettype none

module vector_display_command_decoder_core
    import vdcd_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_draw_kind,
    output logic [15:0]      o_start_x,
    output logic [16:0]      o_start_y_flipped,
    output logic [15:0]      o_end_x,
    output logic [16:0]      o_end_y_flipped
);

    logic  w_take;
    logic  w_res_valid;
    t_draw w_res;
    logic  r_out_valid;
    t_draw r_out;

    // A word is taken unless a result is waiting and the sink stalls.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_take     = i_in_valid && !o_in_stall;

    vdcd_parser #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_data_byte (i_data_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output register: load a new result or drop the one taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_draw_kind       = r_out.kind;
    assign o_start_x         = r_out.start_x;
    assign o_start_y_flipped = r_out.start_y_flipped;
    assign o_end_x           = r_out.end_x;
    assign o_end_y_flipped   = r_out.end_y_flipped;

    // A completed command always shows up at the output next cycle.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_res_valid) |=> o_out_valid)
        else $error("completed command did not reach the output");

    // A point has identical start and end.
    a_point_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_draw_kind == KIND_POINT)) |->
        ((o_start_x == o_end_x) && (o_start_y_flipped == o_end_y_flipped)))
        else $error("point result with differing end points");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
